### design/swba_pkg.sv
// Shared constants and types for the sliding window baseline average unit.
package swba_pkg;

  // Width of one sample and of one baseline word
  localparam int SAMPLE_W = 24;

  // Back end sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } back_state_t;

endpackage

### design/swba_front.sv
// Front end: accepts samples, tracks the window fill and assigns each word its slot.
module swba_front import swba_pkg::*; #(
  parameter int WINDOW_LENGTH = 256
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  output logic [$clog2(WINDOW_LENGTH)-1:0]       cmd_addr,
  output logic                                   cmd_fill,
  output logic [$clog2(WINDOW_LENGTH+1)-1:0]     cmd_count
);

  localparam int AW = $clog2(WINDOW_LENGTH);
  localparam int CW = $clog2(WINDOW_LENGTH + 1);

  logic [CW-1:0] fill_count;
  logic [AW-1:0] oldest_pointer;

  // Classify the word: still filling, or replacing the oldest entry
  assign cmd_fill  = (fill_count != CW'(WINDOW_LENGTH));
  assign cmd_addr  = cmd_fill ? fill_count[AW-1:0] : oldest_pointer;
  assign cmd_count = cmd_fill ? fill_count + CW'(1) : fill_count;

  // Advance the fill count, then the oldest pointer with wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count     <= '0;
      oldest_pointer <= '0;
    end else if (accept) begin
      if (cmd_fill) begin
        fill_count <= fill_count + CW'(1);
      end else if (oldest_pointer == AW'(WINDOW_LENGTH - 1)) begin
        oldest_pointer <= '0;
      end else begin
        oldest_pointer <= oldest_pointer + AW'(1);
      end
    end
  end

endmodule

### design/swba_queue.sv
// Two-entry queue that decouples the front end from the back end.
module swba_queue import swba_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign rd_data = slot[rd_ptr];

  // Hold the payload in the slot under the write pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and the occupancy count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### design/swba_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
module swba_div import swba_pkg::*; #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic        [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] dvd;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] divisor;
  logic             neg;
  logic             busy;
  logic [CNT_W-1:0] step;
  logic [DEN_W:0]   trial;
  logic             qbit;

  // Shift in the next dividend bit and compare against the divisor
  always_comb begin
    trial = {rem, dvd[NUM_W-1]};
    qbit  = (trial >= {1'b0, divisor});
  end

  assign quotient = neg ? -$signed(dvd) : $signed(dvd);

  // Load magnitude on start, then iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[NUM_W-1];
      dvd     <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      rem <= qbit ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      dvd <= {dvd[NUM_W-2:0], qbit};
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/swba_back.sv
// Back end: window memory, running sum, rounded average and result register.
module swba_back import swba_pkg::*; #(
  parameter int WINDOW_LENGTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_pop,
  input  logic signed [SAMPLE_W-1:0]          cmd_sample,
  input  logic [$clog2(WINDOW_LENGTH)-1:0]    cmd_addr,
  input  logic                                cmd_fill,
  input  logic [$clog2(WINDOW_LENGTH+1)-1:0]  cmd_count,
  input  logic                                pop,
  output logic                                empty,
  output logic signed [SAMPLE_W-1:0]          baseline_out,
  output logic                                window_full
);

  localparam int AW    = $clog2(WINDOW_LENGTH);
  localparam int CW    = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int NUM_W = SUM_W + 2;
  localparam int DEN_W = CW + 1;

  back_state_t state;
  back_state_t state_next;

  logic signed [SAMPLE_W-1:0] window_store [WINDOW_LENGTH];
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SAMPLE_W-1:0] sample;
  logic [AW-1:0]              addr;
  logic                       fill;
  logic [CW-1:0]              count;
  logic signed [SUM_W-1:0]    running_sum;
  logic signed [NUM_W-1:0]    num;
  logic [DEN_W-1:0]           den;
  logic                       div_start;
  logic                       div_done;
  logic signed [NUM_W-1:0]    quotient;
  logic                       out_valid;
  logic                       out_load;

  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign div_start = (state == ST_START);
  assign out_load  = (state == ST_DONE) && (!out_valid || pop);
  assign empty     = !out_valid;

  // Numerator 2*sum + count, denominator 2*count
  assign num = $signed({running_sum[SUM_W-1], running_sum, 1'b0}) +
               $signed(NUM_W'(count));
  assign den = {count, 1'b0};

  // Sequence one word at a time
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (cmd_valid) state_next = ST_SUM;
      ST_SUM:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the word and read the entry it replaces
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      sample     <= cmd_sample;
      addr       <= cmd_addr;
      fill       <= cmd_fill;
      count      <= cmd_count;
      old_sample <= window_store[cmd_addr];
    end
  end

  // Write the new sample into its slot
  always_ff @(posedge clk) begin
    if (state == ST_SUM) begin
      window_store[addr] <= sample;
    end
  end

  // Add the new sample; once the window is full, also drop the oldest one
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (state == ST_SUM) begin
      if (fill) begin
        running_sum <= running_sum + SUM_W'(sample);
      end else begin
        running_sum <= running_sum - SUM_W'(old_sample) + SUM_W'(sample);
      end
    end
  end

  swba_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (num),
    .den      (den),
    .done     (div_done),
    .quotient (quotient)
  );

  // Hold the result until it is popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      baseline_out <= quotient[SAMPLE_W-1:0];
      window_full  <= (count == CW'(WINDOW_LENGTH));
    end
  end

endmodule

### design/sliding_window_baseline_average_unit.sv
// Top level of the sliding window baseline average unit.
//
//   channel  | handshake       | payload
//   ---------+-----------------+-------------------------------------
//   input    | push / full     | sample_in (24-bit signed)
//   result   | pop / empty     | baseline_out (24-bit signed), window_full
//
// The bit-serial divider sets the time per word; it works through NUM_W numerator bits,
// NUM_W = 26 + clog2(WINDOW_LENGTH+1), which is 35 at the default length.
// The front end keeps accepting into a two-entry queue, until it is full, while the back end works.
// A finished result waits in the output register; the back end stalls only when
// that register is still occupied at the end of the next word.
// Synchronous reset clears counts, sum and pointers; the window memory needs no clearing.
module sliding_window_baseline_average_unit import swba_pkg::*; #(
  parameter int WINDOW_LENGTH = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [SAMPLE_W-1:0] baseline_out,
  output logic                       window_full
);

  localparam int AW    = $clog2(WINDOW_LENGTH);
  localparam int CW    = $clog2(WINDOW_LENGTH + 1);
  localparam int CMD_W = SAMPLE_W + AW + 1 + CW;

  logic                       accept;
  logic [AW-1:0]              f_addr;
  logic                       f_fill;
  logic [CW-1:0]              f_count;
  logic [CMD_W-1:0]           q_wr_data;
  logic [CMD_W-1:0]           q_rd_data;
  logic                       q_valid;
  logic                       q_pop;
  logic signed [SAMPLE_W-1:0] b_sample;
  logic [AW-1:0]              b_addr;
  logic                       b_fill;
  logic [CW-1:0]              b_count;

  assign accept    = push && !full;
  assign q_wr_data = {sample_in, f_addr, f_fill, f_count};
  assign {b_sample, b_addr, b_fill, b_count} = q_rd_data;

  swba_front #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd_addr  (f_addr),
    .cmd_fill  (f_fill),
    .cmd_count (f_count)
  );

  swba_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_data (q_wr_data),
    .full    (full),
    .rd_en   (q_pop),
    .valid   (q_valid),
    .rd_data (q_rd_data)
  );

  swba_back #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (q_valid),
    .cmd_pop      (q_pop),
    .cmd_sample   (b_sample),
    .cmd_addr     (b_addr),
    .cmd_fill     (b_fill),
    .cmd_count    (b_count),
    .pop          (pop),
    .empty        (empty),
    .baseline_out (baseline_out),
    .window_full  (window_full)
  );

endmodule
